// ----- src/saabb_pkg.sv -----
// ----------------------------------------------------------------------------
// saabb_pkg
// Widths, constants, shared types and helpers for the swept box collision
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package saabb_pkg;

  localparam int COORD_W   = 32;   // signed Q16.16 coordinates and velocities
  localparam int SIZE_W    = 31;   // unsigned box sizes
  localparam int STEP_W    = 24;   // unsigned Q8.16 time step
  localparam int FRAC_BITS = 16;
  localparam int CT_W      = 16;   // Q0.16 contact time
  localparam int NUM_W     = 35;   // slab numerators
  localparam int DISP_W    = 56;   // displacement, 32 fraction bits
  localparam int QUO_BITS  = 47;   // quotient bits below the saturation point
  localparam int LOW_W     = QUO_BITS - 2 * FRAC_BITS;
  localparam int TIME_W    = QUO_BITS + 2;
  localparam int DIV_LAT   = QUO_BITS + 2;
  localparam int DMAG_W    = DISP_W - 2 * FRAC_BITS + CT_W;  // contact offset magnitude
  localparam int BASE_W    = COORD_W + 1;
  localparam int SUM_W     = 44;
  localparam int CUT_W     = COORD_W + 1;

  localparam logic signed [TIME_W-1:0] TIME_SAT = TIME_W'(64'sd1 <<< QUO_BITS);
  localparam logic signed [TIME_W-1:0] TIME_ONE = TIME_W'(64'sd1 <<< FRAC_BITS);

  localparam logic signed [1:0] NORM_NONE = 2'sb00;
  localparam logic signed [1:0] NORM_POS  = 2'sb01;
  localparam logic signed [1:0] NORM_NEG  = 2'sb11;

  // item context that travels beside the dividers
  typedef struct packed {
    logic                      valid;
    logic                      vnz;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [BASE_W-1:0]  base_x;
    logic signed [BASE_W-1:0]  base_y;
    logic [DISP_W-1:0]         udx;
    logic [DISP_W-1:0]         udy;
    logic                      dx_neg;
    logic                      dy_neg;
    logic                      dx_zero;
    logic                      dy_zero;
    logic                      x_inside;
    logic                      y_inside;
  } side_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(64'sd2147483647);
    lo = SUM_W'(-64'sd2147483648);
    if (v > hi) begin
      sat_coord = COORD_W'(hi);
    end else if (v < lo) begin
      sat_coord = COORD_W'(lo);
    end else begin
      sat_coord = v[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/saabb_div.sv -----
// ----------------------------------------------------------------------------
// saabb_div
// Pipelined restoring divider: t = n * 2^32 / d, truncated toward zero and
// saturated to +-2^47. One quotient bit per stage, one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module saabb_div (
  input  wire logic                                    clk,
  input  wire logic signed [saabb_pkg::NUM_W-1:0]      n_i,
  input  wire logic signed [saabb_pkg::DISP_W-1:0]     d_i,
  output logic signed [saabb_pkg::TIME_W-1:0]          t_o
);

  localparam int NW = saabb_pkg::NUM_W;
  localparam int DW = saabb_pkg::DISP_W;
  localparam int QB = saabb_pkg::QUO_BITS;
  localparam int LW = saabb_pkg::LOW_W;
  localparam int FB2 = 2 * saabb_pkg::FRAC_BITS;

  logic [NW-1:0] un;
  logic [DW-1:0] ud;
  logic          sat_nxt;

  logic [DW-1:0] ud_r   [0:QB];
  logic [DW-1:0] rem_r  [0:QB];
  logic [QB-1:0] quo_r  [0:QB];
  logic [LW-1:0] low_r  [0:QB];
  logic          neg_r  [0:QB];
  logic          sat_r  [0:QB];
  logic signed [saabb_pkg::TIME_W-1:0] t_r;
  logic signed [saabb_pkg::TIME_W-1:0] t_nxt;
  logic [saabb_pkg::TIME_W-2:0]        mag;

  assign un = n_i[NW-1] ? NW'(-n_i) : NW'(n_i);
  assign ud = d_i[DW-1] ? DW'(-d_i) : DW'(d_i);
  // quotient reaches 2^47 exactly when |n| >= |d| * 2^15
  assign sat_nxt = ({(DW + LW - NW)'(0), un} >= {ud, LW'(0)});

  always_ff @(posedge clk) begin
    ud_r[0]  <= ud;
    rem_r[0] <= DW'(un >> LW);
    quo_r[0] <= '0;
    low_r[0] <= un[LW-1:0];
    neg_r[0] <= n_i[NW-1] ^ d_i[DW-1];
    sat_r[0] <= sat_nxt;
  end

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_stage
      localparam int BI = QB - 1 - k;
      logic          in_bit;
      logic [DW:0]   trial;
      logic          ge;
      if (BI >= FB2) begin : g_lo
        assign in_bit = low_r[k][BI-FB2];
      end else begin : g_zero
        assign in_bit = 1'b0;
      end
      assign trial = {rem_r[k], in_bit};
      assign ge    = trial >= {1'b0, ud_r[k]};
      always_ff @(posedge clk) begin
        rem_r[k+1] <= ge ? DW'(trial - {1'b0, ud_r[k]}) : DW'(trial);
        quo_r[k+1] <= {quo_r[k][QB-2:0], ge};
        ud_r[k+1]  <= ud_r[k];
        low_r[k+1] <= low_r[k];
        neg_r[k+1] <= neg_r[k];
        sat_r[k+1] <= sat_r[k];
      end
    end
  endgenerate

  assign mag   = sat_r[QB] ? (saabb_pkg::TIME_W - 1)'(saabb_pkg::TIME_SAT)
                           : {1'b0, quo_r[QB]};
  assign t_nxt = neg_r[QB] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
  end

  assign t_o = t_r;

endmodule

`default_nettype wire

// ----- src/swept_aabb_collision_response.sv -----
// ----------------------------------------------------------------------------
// swept_aabb_collision_response
// Swept box against fixed box: slab test, contact point, normal and
// velocity response, fully pipelined.
// ----------------------------------------------------------------------------
// A word is taken on every clock edge where start is high; busy is always low,
// so one box pair enters per cycle. Its result is marked by out_valid for one
// cycle, in the order taken; the receiver cannot stall. The four slab dividers
// resolve one quotient bit per stage over 47 stages, with input, product,
// compare, multiply and saturation stages around them.
`default_nettype none

module swept_aabb_collision_response (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [saabb_pkg::COORD_W-1:0]   in_mover_x,
  input  wire logic signed [saabb_pkg::COORD_W-1:0]   in_mover_y,
  input  wire logic [saabb_pkg::SIZE_W-1:0]           in_mover_width,
  input  wire logic [saabb_pkg::SIZE_W-1:0]           in_mover_height,
  input  wire logic signed [saabb_pkg::COORD_W-1:0]   in_velocity_x,
  input  wire logic signed [saabb_pkg::COORD_W-1:0]   in_velocity_y,
  input  wire logic signed [saabb_pkg::COORD_W-1:0]   in_target_x,
  input  wire logic signed [saabb_pkg::COORD_W-1:0]   in_target_y,
  input  wire logic [saabb_pkg::SIZE_W-1:0]           in_target_width,
  input  wire logic [saabb_pkg::SIZE_W-1:0]           in_target_height,
  input  wire logic [saabb_pkg::STEP_W-1:0]           in_time_step,
  output logic                                        out_valid,
  output logic                                        out_hit,
  output logic [saabb_pkg::CT_W-1:0]                  out_contact_time,
  output logic signed [saabb_pkg::COORD_W-1:0]        out_contact_x,
  output logic signed [saabb_pkg::COORD_W-1:0]        out_contact_y,
  output logic signed [1:0]                           out_normal_x,
  output logic signed [1:0]                           out_normal_y,
  output logic signed [saabb_pkg::COORD_W-1:0]        out_new_velocity_x,
  output logic signed [saabb_pkg::COORD_W-1:0]        out_new_velocity_y
);

  localparam int CW = saabb_pkg::COORD_W;
  localparam int NW = saabb_pkg::NUM_W;
  localparam int DW = saabb_pkg::DISP_W;
  localparam int TW = saabb_pkg::TIME_W;
  localparam int BW = saabb_pkg::BASE_W;
  localparam int SW = saabb_pkg::SUM_W;
  localparam int MW = saabb_pkg::DMAG_W;
  localparam int UW = saabb_pkg::CUT_W;
  localparam int TCW = saabb_pkg::CT_W;
  localparam int LAT = saabb_pkg::DIV_LAT;

  assign busy = 1'b0;

  // stage 0: input word
  logic                         v0_r;
  logic signed [CW-1:0]         mx0_r, my0_r, vx0_r, vy0_r, tx0_r, ty0_r;
  logic [saabb_pkg::SIZE_W-1:0] mw0_r, mh0_r, tw0_r, th0_r;
  logic [saabb_pkg::STEP_W-1:0] ts0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    mx0_r <= in_mover_x;
    my0_r <= in_mover_y;
    mw0_r <= in_mover_width;
    mh0_r <= in_mover_height;
    vx0_r <= in_velocity_x;
    vy0_r <= in_velocity_y;
    tx0_r <= in_target_x;
    ty0_r <= in_target_y;
    tw0_r <= in_target_width;
    th0_r <= in_target_height;
    ts0_r <= in_time_step;
  end

  // stage 1: displacement products, slab numerators, center
  logic                 v1_r, vnz1_r;
  logic signed [CW-1:0] vx1_r, vy1_r;
  logic signed [DW-1:0] dx1_r, dy1_r;
  logic signed [NW-1:0] nxn1_r, nxf1_r, nyn1_r, nyf1_r;
  logic signed [BW-1:0] bx1_r, by1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    vx1_r  <= vx0_r;
    vy1_r  <= vy0_r;
    vnz1_r <= (vx0_r != '0) || (vy0_r != '0);
    dx1_r  <= DW'(vx0_r) * DW'($signed({1'b0, ts0_r}));
    dy1_r  <= DW'(vy0_r) * DW'($signed({1'b0, ts0_r}));
    nxn1_r <= $signed(NW'(tx0_r) - NW'(mx0_r) - NW'(mw0_r));
    nxf1_r <= $signed(NW'(tx0_r) + NW'(tw0_r) - NW'(mx0_r));
    nyn1_r <= $signed(NW'(ty0_r) - NW'(my0_r) - NW'(mh0_r));
    nyf1_r <= $signed(NW'(ty0_r) + NW'(th0_r) - NW'(my0_r));
    bx1_r  <= $signed(BW'(mx0_r) + BW'(mw0_r >> 1));
    by1_r  <= $signed(BW'(my0_r) + BW'(mh0_r >> 1));
  end

  // slab dividers
  logic signed [TW-1:0] txn, txf, tyn, tyf;

  saabb_div u_div_xn (.clk(clk), .n_i(nxn1_r), .d_i(dx1_r), .t_o(txn));
  saabb_div u_div_xf (.clk(clk), .n_i(nxf1_r), .d_i(dx1_r), .t_o(txf));
  saabb_div u_div_yn (.clk(clk), .n_i(nyn1_r), .d_i(dy1_r), .t_o(tyn));
  saabb_div u_div_yf (.clk(clk), .n_i(nyf1_r), .d_i(dy1_r), .t_o(tyf));

  // context line beside the dividers
  saabb_pkg::side_t side_nxt;
  saabb_pkg::side_t side_r [0:LAT-1];

  always_comb begin
    side_nxt.valid    = v1_r;
    side_nxt.vnz      = vnz1_r;
    side_nxt.vx       = vx1_r;
    side_nxt.vy       = vy1_r;
    side_nxt.base_x   = bx1_r;
    side_nxt.base_y   = by1_r;
    side_nxt.udx      = dx1_r[DW-1] ? DW'(-dx1_r) : DW'(dx1_r);
    side_nxt.udy      = dy1_r[DW-1] ? DW'(-dy1_r) : DW'(dy1_r);
    side_nxt.dx_neg   = dx1_r[DW-1];
    side_nxt.dy_neg   = dy1_r[DW-1];
    side_nxt.dx_zero  = (dx1_r == '0);
    side_nxt.dy_zero  = (dy1_r == '0);
    side_nxt.x_inside = (nxn1_r < 0) && (nxf1_r > 0);
    side_nxt.y_inside = (nyn1_r < 0) && (nyf1_r > 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        side_r[i].valid <= 1'b0;
      end
    end else begin
      side_r[0].valid <= side_nxt.valid;
      for (int i = 1; i < LAT; i++) begin
        side_r[i].valid <= side_r[i-1].valid;
      end
    end
    side_r[0][$bits(saabb_pkg::side_t)-2:0] <= side_nxt[$bits(saabb_pkg::side_t)-2:0];
    for (int i = 1; i < LAT; i++) begin
      side_r[i][$bits(saabb_pkg::side_t)-2:0] <= side_r[i-1][$bits(saabb_pkg::side_t)-2:0];
    end
  end

  // stage a: order each axis' times, zero-displacement axes
  saabb_pkg::side_t     sa_r;
  logic                 okx_a_r, oky_a_r;
  logic signed [TW-1:0] xn_a_r, xf_a_r, yn_a_r, yf_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_r.valid <= 1'b0;
    end else begin
      sa_r.valid <= side_r[LAT-1].valid;
    end
    sa_r[$bits(saabb_pkg::side_t)-2:0] <= side_r[LAT-1][$bits(saabb_pkg::side_t)-2:0];
    if (side_r[LAT-1].dx_zero) begin
      okx_a_r <= side_r[LAT-1].x_inside;
      xn_a_r  <= -saabb_pkg::TIME_SAT;
      xf_a_r  <= saabb_pkg::TIME_SAT;
    end else begin
      okx_a_r <= 1'b1;
      xn_a_r  <= (txn > txf) ? txf : txn;
      xf_a_r  <= (txn > txf) ? txn : txf;
    end
    if (side_r[LAT-1].dy_zero) begin
      oky_a_r <= side_r[LAT-1].y_inside;
      yn_a_r  <= -saabb_pkg::TIME_SAT;
      yf_a_r  <= saabb_pkg::TIME_SAT;
    end else begin
      oky_a_r <= 1'b1;
      yn_a_r  <= (tyn > tyf) ? tyf : tyn;
      yf_a_r  <= (tyn > tyf) ? tyn : tyf;
    end
  end

  // stage b: hit decision, contact time, normal
  logic                 hit_b;
  logic signed [TW-1:0] tent_b, tfar_b;
  saabb_pkg::side_t     sb_r;
  logic                 hit_b_r;
  logic [TCW-1:0]       ct_b_r;
  logic signed [1:0]    nx_b_r, ny_b_r;

  assign tent_b = (xn_a_r > yn_a_r) ? xn_a_r : yn_a_r;
  assign tfar_b = (xf_a_r < yf_a_r) ? xf_a_r : yf_a_r;
  assign hit_b  = sa_r.vnz && okx_a_r && oky_a_r
                  && !((xn_a_r > yf_a_r) || (yn_a_r > xf_a_r))
                  && (tfar_b >= 0) && (tent_b >= 0) && (tent_b < saabb_pkg::TIME_ONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r.valid <= 1'b0;
    end else begin
      sb_r.valid <= sa_r.valid;
    end
    sb_r[$bits(saabb_pkg::side_t)-2:0] <= sa_r[$bits(saabb_pkg::side_t)-2:0];
    hit_b_r <= hit_b;
    ct_b_r  <= hit_b ? tent_b[TCW-1:0] : '0;
    nx_b_r  <= saabb_pkg::NORM_NONE;
    ny_b_r  <= saabb_pkg::NORM_NONE;
    if (hit_b && (xn_a_r > yn_a_r)) begin
      nx_b_r <= sa_r.dx_neg ? saabb_pkg::NORM_POS : saabb_pkg::NORM_NEG;
    end else if (hit_b && (xn_a_r < yn_a_r)) begin
      ny_b_r <= sa_r.dy_neg ? saabb_pkg::NORM_POS : saabb_pkg::NORM_NEG;
    end
  end

  // stage c: contact offsets and velocity cuts
  saabb_pkg::side_t  sc_r;
  logic              hit_c_r;
  logic [TCW-1:0]    ct_c_r;
  logic signed [1:0] nx_c_r, ny_c_r;
  logic [MW-1:0]     mx_c_r, my_c_r;
  logic [UW-1:0]     cutx_c_r, cuty_c_r;
  logic [DW+TCW-1:0] prx_c, pry_c;
  logic [CW-1:0]     avx_c, avy_c;
  logic [TCW:0]      rem_c;
  logic [CW+TCW:0]   pcx_c, pcy_c;

  assign prx_c = ct_b_r * sb_r.udx;
  assign pry_c = ct_b_r * sb_r.udy;
  assign avx_c = sb_r.vx[CW-1] ? CW'(-sb_r.vx) : CW'(sb_r.vx);
  assign avy_c = sb_r.vy[CW-1] ? CW'(-sb_r.vy) : CW'(sb_r.vy);
  assign rem_c = (TCW + 1)'(saabb_pkg::TIME_ONE) - (TCW + 1)'(ct_b_r);
  assign pcx_c = avx_c * rem_c;
  assign pcy_c = avy_c * rem_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r.valid <= 1'b0;
    end else begin
      sc_r.valid <= sb_r.valid;
    end
    sc_r[$bits(saabb_pkg::side_t)-2:0] <= sb_r[$bits(saabb_pkg::side_t)-2:0];
    hit_c_r  <= hit_b_r;
    ct_c_r   <= ct_b_r;
    nx_c_r   <= nx_b_r;
    ny_c_r   <= ny_b_r;
    mx_c_r   <= prx_c[DW+TCW-1:2*saabb_pkg::FRAC_BITS];
    my_c_r   <= pry_c[DW+TCW-1:2*saabb_pkg::FRAC_BITS];
    cutx_c_r <= UW'(pcx_c >> saabb_pkg::FRAC_BITS);
    cuty_c_r <= UW'(pcy_c >> saabb_pkg::FRAC_BITS);
  end

  // stage d: sums, saturation, result word
  logic signed [SW-1:0] offx_d, offy_d, sumx_d, sumy_d, nvx_d, nvy_d;

  assign offx_d = sc_r.dx_neg ? -$signed(SW'(mx_c_r)) : $signed(SW'(mx_c_r));
  assign offy_d = sc_r.dy_neg ? -$signed(SW'(my_c_r)) : $signed(SW'(my_c_r));
  assign sumx_d = SW'(sc_r.base_x) + offx_d;
  assign sumy_d = SW'(sc_r.base_y) + offy_d;
  assign nvx_d  = (nx_c_r == saabb_pkg::NORM_POS) ? SW'(sc_r.vx) + $signed(SW'(cutx_c_r))
                                                  : SW'(sc_r.vx) - $signed(SW'(cutx_c_r));
  assign nvy_d  = (ny_c_r == saabb_pkg::NORM_POS) ? SW'(sc_r.vy) + $signed(SW'(cuty_c_r))
                                                  : SW'(sc_r.vy) - $signed(SW'(cuty_c_r));

  logic                 out_valid_r, out_hit_r;
  logic [TCW-1:0]       out_ct_r;
  logic signed [CW-1:0] out_cx_r, out_cy_r, out_nvx_r, out_nvy_r;
  logic signed [1:0]    out_nx_r, out_ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sc_r.valid;
    end
    out_hit_r <= hit_c_r;
    out_ct_r  <= ct_c_r;
    out_nx_r  <= nx_c_r;
    out_ny_r  <= ny_c_r;
    out_cx_r  <= hit_c_r ? saabb_pkg::sat_coord(sumx_d) : '0;
    out_cy_r  <= hit_c_r ? saabb_pkg::sat_coord(sumy_d) : '0;
    // corner or miss keeps the velocity as is
    out_nvx_r <= (nx_c_r == saabb_pkg::NORM_NONE) ? sc_r.vx : saabb_pkg::sat_coord(nvx_d);
    out_nvy_r <= (ny_c_r == saabb_pkg::NORM_NONE) ? sc_r.vy : saabb_pkg::sat_coord(nvy_d);
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_contact_time   = out_ct_r;
  assign out_contact_x      = out_cx_r;
  assign out_contact_y      = out_cy_r;
  assign out_normal_x       = out_nx_r;
  assign out_normal_y       = out_ny_r;
  assign out_new_velocity_x = out_nvx_r;
  assign out_new_velocity_y = out_nvy_r;

endmodule

`default_nettype wire

// ----- src/saabb_checker.sv -----
// ----------------------------------------------------------------------------
// saabb_checker
// Port-level checks on the collision pipeline's busy output and result words.
// ----------------------------------------------------------------------------
`default_nettype none

module saabb_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               busy,
  input wire logic                               out_valid,
  input wire logic                               out_hit,
  input wire logic [saabb_pkg::CT_W-1:0]         out_contact_time,
  input wire logic signed [saabb_pkg::COORD_W-1:0] out_contact_x,
  input wire logic signed [saabb_pkg::COORD_W-1:0] out_contact_y,
  input wire logic signed [1:0]                  out_normal_x,
  input wire logic signed [1:0]                  out_normal_y
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("pipeline refused a word");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_contact_time == '0 && out_contact_x == '0
      && out_contact_y == '0 && out_normal_x == 2'sb00 && out_normal_y == 2'sb00)
    else $error("miss word carries contact data");

  a_one_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_normal_x != 2'sb00 |-> out_normal_y == 2'sb00)
    else $error("normal on both axes");

  a_normal_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_normal_x != 2'sb00 || out_normal_y != 2'sb00) |-> out_hit
      && out_normal_x != 2'sb10 && out_normal_y != 2'sb10)
    else $error("bad normal");

endmodule

bind swept_aabb_collision_response saabb_checker u_saabb_checker (
  .clk(clk),
  .rst_n(rst_n),
  .busy(busy),
  .out_valid(out_valid),
  .out_hit(out_hit),
  .out_contact_time(out_contact_time),
  .out_contact_x(out_contact_x),
  .out_contact_y(out_contact_y),
  .out_normal_x(out_normal_x),
  .out_normal_y(out_normal_y)
);

`default_nettype wire
